// ----- design/isns_pkg.sv -----
// ----------------------------------------------------------------------------
// isns_pkg: shared types and constants of the interval schedule calculator
// Field widths, register indexes, event codes, base modes, sequencer states
// and the control groups between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package isns_pkg;

    localparam int TIME_BITS_DEF = 40;
    localparam int FIELD_W       = 40;
    localparam int INTERVAL_W    = 32;
    localparam int FUNC_W        = 2;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 40;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(60);

    // event codes
    localparam logic [FUNC_W-1:0] FUNC_CALC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;

    // tick base modes
    localparam logic [MODE_W-1:0] BASE_SMART = 2'd0;
    localparam logic [MODE_W-1:0] BASE_START = 2'd1;
    localparam logic [MODE_W-1:0] BASE_LAST  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNBOUNDED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMART     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_ONE   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV,
        ST_CHECK,
        ST_FINISH,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [INTERVAL_W-1:0] divisor;
    } t_rem_ctl;

    typedef struct packed {
        logic                  done;
        logic [INTERVAL_W-1:0] rem;
    } t_rem_sts;

endpackage

// ----- design/isns_rem.sv -----
// ----------------------------------------------------------------------------
// isns_rem: serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module isns_rem import isns_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_rem_ctl             i_ctl,
    input  logic [TIME_BITS-1:0] i_dividend,
    output t_rem_sts             o_sts
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [INTERVAL_W-1:0] r_rem;
    logic [INTERVAL_W-1:0] r_div;
    logic [TIME_BITS-1:0]  r_dvd;

    logic [INTERVAL_W:0]   trial;
    logic [INTERVAL_W:0]   trial_sub;
    logic                  fits;
    logic [INTERVAL_W-1:0] n_rem;

    assign trial     = {r_rem, r_dvd[TIME_BITS-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign fits      = trial >= {1'b0, r_div};
    assign n_rem     = fits ? trial_sub[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_div <= i_ctl.divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[TIME_BITS-2:0], 1'b0};
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

endmodule

// ----- design/interval_schedule_next_start_top.sv -----
// ----------------------------------------------------------------------------
// interval_schedule_next_start_top: periodic schedule point calculator
// Keeps the next start and last finish times of a periodic schedule and
// answers each event with one result.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   event    | in        | i_in_valid / o_in_stall| i_func, i_now_time,
//            |           |                        | i_given_finish
//   result   | out       | o_out_valid/i_out_stall| o_next_start, o_next_known,
//            |           |                        | o_reschedule, o_last_finish,
//            |           |                        | o_last_finish_known
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A calculate event passes the difference, remainder, check and result states;
// the serial remainder loop takes one dividend bit per cycle. Finish events
// go from the finish state to the result state, and calculate events whose
// time is not past the base skip the remainder loop.
// Reset is synchronous, active low; it restores register defaults and clears
// the stored times and flags.
// One event is in work at a time; o_in_stall is high while it is. A result
// waiting under i_out_stall holds in the output register, and the next event
// is taken meanwhile.
// ----------------------------------------------------------------------------
module interval_schedule_next_start_top import isns_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [FIELD_W-1:0]    i_now_time,
    input  logic [FIELD_W-1:0]    i_given_finish,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FIELD_W-1:0]    o_next_start,
    output logic                  o_next_known,
    output logic                  o_reschedule,
    output logic [FIELD_W-1:0]    o_last_finish,
    output logic                  o_last_finish_known,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer
    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [INTERVAL_W-1:0] r_interval;
    logic [TIME_BITS-1:0]  r_start_time;
    logic [TIME_BITS-1:0]  r_end_time;
    logic                  r_end_unbounded;
    logic                  r_skip_missed;
    logic [MODE_W-1:0]     r_base_mode;
    logic [TIME_BITS-1:0]  r_smart_base;
    logic                  r_day_one;

    // schedule state
    logic [TIME_BITS-1:0]  r_next_start;
    logic                  r_next_known;
    logic [TIME_BITS-1:0]  r_last_finish;
    logic                  r_lf_known;

    // event in work
    logic [FUNC_W-1:0]     r_func;
    logic [TIME_BITS-1:0]  r_now;
    logic [TIME_BITS-1:0]  r_given;
    logic [TIME_BITS-1:0]  r_sum;
    logic [TIME_BITS-1:0]  r_nxt;

    // output register
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_next_start;
    logic                  r_out_next_known;
    logic                  r_out_resched;
    logic [FIELD_W-1:0]    r_out_last_finish;
    logic                  r_out_lf_known;

    logic                  in_xfer;
    logic                  out_load;
    logic [INTERVAL_W-1:0] iv_eff;
    logic [TIME_BITS-1:0]  base_sel;
    logic [TIME_BITS-1:0]  base_diff;
    logic                  past_base;
    logic [TIME_BITS-1:0]  d_start;
    logic [TIME_BITS-1:0]  d_last;
    logic                  catch_up;
    logic [INTERVAL_W-1:0] d_end;
    logic                  resched;
    t_rem_ctl              rem_ctl;
    t_rem_sts              rem_sts;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // a zero interval acts as one second
    assign iv_eff = (r_interval == '0) ? INTERVAL_W'(1) : r_interval;

    // pick the tick base
    always_comb begin
        case (r_base_mode)
            BASE_START: base_sel = r_start_time;
            BASE_LAST:  base_sel = r_lf_known ? r_last_finish : r_start_time;
            default:    base_sel = r_smart_base;
        endcase
    end

    assign base_diff = r_now - base_sel;
    assign past_base = r_now > base_sel;

    // next tick is now - ((now - base) mod interval) + interval
    isns_rem #(
        .TIME_BITS (TIME_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rem_ctl),
        .i_dividend (base_diff),
        .o_sts      (rem_sts)
    );

    assign rem_ctl.start   = (r_state == ST_DIFF) && past_base;
    assign rem_ctl.divisor = iv_eff;

    // catch-up run when ticks were missed and skipping is off
    assign d_start = r_nxt - r_start_time;
    assign d_last  = r_nxt - r_last_finish;
    always_comb begin
        catch_up = 1'b0;
        if (!r_skip_missed) begin
            if (!r_lf_known) begin
                catch_up = !r_day_one && (d_start[INTERVAL_W-1:0] > iv_eff);
            end else begin
                catch_up = (r_nxt > r_last_finish) && (d_last[INTERVAL_W-1:0] > iv_eff);
            end
        end
    end

    // reschedule flag from the stored next start, low 32 bits only
    assign d_end   = r_end_time[INTERVAL_W-1:0] - r_next_start[INTERVAL_W-1:0];
    assign resched = r_end_unbounded || (d_end > iv_eff);

    assign out_load = (r_state == ST_RESULT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_func == FUNC_CALC) ? ST_DIFF : ST_FINISH;
                end
            end
            ST_DIFF: begin
                n_state = past_base ? ST_DIV : ST_CHECK;
            end
            ST_DIV: begin
                if (rem_sts.done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK:  n_state = ST_RESULT;
            ST_FINISH: n_state = ST_RESULT;
            ST_RESULT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and schedule state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_interval      <= INTERVAL_RESET;
            r_start_time    <= '0;
            r_end_time      <= '0;
            r_end_unbounded <= 1'b1;
            r_skip_missed   <= 1'b0;
            r_base_mode     <= BASE_SMART;
            r_smart_base    <= '0;
            r_day_one       <= 1'b0;
            r_next_start    <= '0;
            r_next_known    <= 1'b0;
            r_last_finish   <= '0;
            r_lf_known      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INTERVAL:  r_interval      <= i_cfg_data[INTERVAL_W-1:0];
                    REG_START:     r_start_time    <= TIME_BITS'(i_cfg_data);
                    REG_END:       r_end_time      <= TIME_BITS'(i_cfg_data);
                    REG_UNBOUNDED: r_end_unbounded <= i_cfg_data[0];
                    REG_SKIP:      r_skip_missed   <= i_cfg_data[0];
                    REG_BASE_MODE: r_base_mode     <= i_cfg_data[MODE_W-1:0];
                    REG_SMART:     r_smart_base    <= TIME_BITS'(i_cfg_data);
                    REG_DAY_ONE:   r_day_one       <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_state == ST_CHECK) begin
                r_next_start <= catch_up ? r_now : r_nxt;
                r_next_known <= 1'b1;
            end

            // finish events pass the plausibility checks or drop
            if (r_state == ST_FINISH) begin
                case (r_func)
                    FUNC_FINISH: begin
                        if (r_now > r_start_time) begin
                            r_last_finish <= r_now;
                            r_lf_known    <= 1'b1;
                        end
                    end
                    FUNC_SET: begin
                        if ((r_now > r_given) && (r_given > r_start_time)) begin
                            r_last_finish <= r_given;
                            r_lf_known    <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the event in work and of the output register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func  <= i_func;
            r_now   <= TIME_BITS'(i_now_time);
            r_given <= TIME_BITS'(i_given_finish);
        end

        if (r_state == ST_DIFF) begin
            r_sum <= r_now + TIME_BITS'(iv_eff);
            if (!past_base) begin
                r_nxt <= base_sel;
            end
        end

        if ((r_state == ST_DIV) && rem_sts.done) begin
            r_nxt <= r_sum - TIME_BITS'(rem_sts.rem);
        end

        if (out_load) begin
            r_out_next_start  <= FIELD_W'(r_next_start);
            r_out_next_known  <= r_next_known;
            r_out_resched     <= resched;
            r_out_last_finish <= FIELD_W'(r_last_finish);
            r_out_lf_known    <= r_lf_known;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_next_start        = r_out_next_start;
    assign o_next_known        = r_out_next_known;
    assign o_reschedule        = r_out_resched;
    assign o_last_finish       = r_out_last_finish;
    assign o_last_finish_known = r_out_lf_known;

endmodule

// ----- design/isns_chk.sv -----
// ----------------------------------------------------------------------------
// isns_chk: port-level checks of the interval schedule calculator
// Tracks transfers on both channels and checks ordering and sticky flags.
// ----------------------------------------------------------------------------
module isns_chk import isns_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [FIELD_W-1:0]    o_next_start,
    input logic                  o_next_known,
    input logic [FIELD_W-1:0]    o_last_finish,
    input logic                  o_last_finish_known
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pending;
    logic       r_known_seen;
    logic       r_lf_seen;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // count events taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= '0;
            r_known_seen <= 1'b0;
            r_lf_seen    <= 1'b0;
        end else begin
            r_pending <= r_pending + {1'b0, in_xfer} - {1'b0, out_xfer};
            if (out_xfer && o_next_known) begin
                r_known_seen <= 1'b1;
            end
            if (out_xfer && o_last_finish_known) begin
                r_lf_seen <= 1'b1;
            end
        end
    end

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("event transfer did not make the block busy");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_next_start) && $stable(o_last_finish)))
        else $error("stalled result changed or vanished");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 2'd0))
        else $error("result shown with no event outstanding");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (r_pending <= 2'd1))
        else $error("block idle while an event is still unanswered");

    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_next_known || !r_known_seen) &&
                         (o_last_finish_known || !r_lf_seen)))
        else $error("known flag cleared after being reported");

endmodule

bind interval_schedule_next_start_top isns_chk u_isns_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the interval schedule calculator
// Drives schedule events and register writes, predicts each result from a
// behavioral copy of the schedule state, and compares every field. Directed
// corner cases come first, then random schedules under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import isns_pkg::*;

    // codes outside the documented ranges, still legal on the ports
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;
    localparam logic [MODE_W-1:0] BASE_ALIAS = 2'd3;

    localparam logic [FIELD_W-1:0] TIME_MAX = {FIELD_W{1'b1}};

    localparam int SETTLE_CYCLES  = 64;    // idle time after every result is back
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer

    typedef struct packed {
        logic [FIELD_W-1:0] next_start;
        logic               next_known;
        logic               reschedule;
        logic [FIELD_W-1:0] last_finish;
        logic               last_finish_known;
    } sched_result_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [FUNC_W-1:0]     i_func;
    logic [FIELD_W-1:0]    i_now_time;
    logic [FIELD_W-1:0]    i_given_finish;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [FIELD_W-1:0]    o_next_start;
    logic                  o_next_known;
    logic                  o_reschedule;
    logic [FIELD_W-1:0]    o_last_finish;
    logic                  o_last_finish_known;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    interval_schedule_next_start_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_now_time          (i_now_time),
        .i_given_finish      (i_given_finish),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_next_start        (o_next_start),
        .o_next_known        (o_next_known),
        .o_reschedule        (o_reschedule),
        .o_last_finish       (o_last_finish),
        .o_last_finish_known (o_last_finish_known),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow of the block: registers and stored schedule state
    // ------------------------------------------------------------------------
    logic [INTERVAL_W-1:0] cfg_interval;
    logic [FIELD_W-1:0]    cfg_start;
    logic [FIELD_W-1:0]    cfg_end;
    logic                  cfg_unbounded;
    logic                  cfg_skip;
    logic [MODE_W-1:0]     cfg_base_mode;
    logic [FIELD_W-1:0]    cfg_smart;
    logic                  cfg_day_one;

    logic [FIELD_W-1:0]    sched_next;
    logic                  sched_next_known;
    logic [FIELD_W-1:0]    sched_last_finish;
    logic                  sched_finish_known;

    sched_result_t         pending_results[$];

    // stimulus state of the random schedules
    logic [FIELD_W-1:0]    sched_anchor;
    logic [FIELD_W-1:0]    sched_clock;

    // bench control and statistics
    bit                    quiet;          // no idling on either side
    bit                    hold_trigger;   // toggle to request a long hold-off
    bit                    hold_seen;
    int                    hold_left;
    int                    fail_count;
    int                    results_checked;
    int                    reg_writes;
    int                    event_count[4];
    int                    idle_cycles;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [31:0] low32(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] d;
        d = a - b;
        return d[31:0];
    endfunction

    function automatic logic [63:0] period();
        return (cfg_interval == '0) ? 64'd1 : {32'd0, cfg_interval};
    endfunction

    // Apply one event to the shadow state and return the result it causes.
    function automatic sched_result_t advance_schedule(logic [FUNC_W-1:0] f,
                                                       logic [FIELD_W-1:0] now,
                                                       logic [FIELD_W-1:0] given);
        logic [63:0]        iv;
        logic [63:0]        base;
        logic [63:0]        ticks;
        logic [63:0]        sum;
        logic [FIELD_W-1:0] nxt;
        sched_result_t      r;
        iv = period();
        case (f)
            FUNC_CALC: begin
                if (cfg_base_mode == BASE_START)
                    base = 64'(cfg_start);
                else if (cfg_base_mode == BASE_LAST)
                    base = 64'(sched_finish_known ? sched_last_finish : cfg_start);
                else
                    base = 64'(cfg_smart);   // smart base, also for the alias code
                if (64'(now) > base) begin
                    ticks = (64'(now) - base) / iv + 64'd1;
                    sum   = base + ticks * iv;
                    nxt   = sum[FIELD_W-1:0];   // wrap at the time width
                end else begin
                    nxt = base[FIELD_W-1:0];
                end
                // one catch-up run when ticks were missed
                if (!cfg_skip) begin
                    if (!sched_finish_known) begin
                        if (!cfg_day_one && low32(nxt, cfg_start) > iv[31:0])
                            nxt = now;
                    end else if (nxt > sched_last_finish &&
                                 low32(nxt, sched_last_finish) > iv[31:0]) begin
                        nxt = now;
                    end
                end
                sched_next       = nxt;
                sched_next_known = 1'b1;
            end
            FUNC_FINISH: begin
                if (now > cfg_start) begin
                    sched_last_finish  = now;
                    sched_finish_known = 1'b1;
                end
            end
            FUNC_SET: begin
                if (now > given && given > cfg_start) begin
                    sched_last_finish  = given;
                    sched_finish_known = 1'b1;
                end
            end
            default: ;   // unknown code: state holds, result still goes out
        endcase
        r.next_start        = sched_next;
        r.next_known        = sched_next_known;
        r.reschedule        = cfg_unbounded ? 1'b1 :
                              (low32(cfg_end, sched_next) > iv[31:0]);
        r.last_finish       = sched_last_finish;
        r.last_finish_known = sched_finish_known;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] rand_time();
        logic [7:0]  hi;
        logic [31:0] lo;
        hi = 8'($urandom_range(0, 255));
        lo = $urandom;
        return {hi, lo};
    endfunction

    // random offset in [0, span)
    function automatic logic [63:0] jitter(logic [63:0] span);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (span == 64'd0) ? 64'd0 : r % span;
    endfunction

    // ------------------------------------------------------------------------
    // Event sender: optional idle gap, then offer until the transfer happens
    // ------------------------------------------------------------------------
    task automatic send_event(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] now,
                              logic [FIELD_W-1:0] given);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_now_time     <= now;
        i_given_finish <= given;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transfer at this edge: predict now, the registers cannot change
        // while anything is in flight
        pending_results.push_back(advance_schedule(f, now, given));
        event_count[f]++;
    endtask

    // Drop valid and wait until every expected result has come, then settle.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_INTERVAL:  cfg_interval  = value[INTERVAL_W-1:0];
            REG_START:     cfg_start     = value[FIELD_W-1:0];
            REG_END:       cfg_end       = value[FIELD_W-1:0];
            REG_UNBOUNDED: cfg_unbounded = value[0];
            REG_SKIP:      cfg_skip      = value[0];
            REG_BASE_MODE: cfg_base_mode = value[MODE_W-1:0];
            REG_SMART:     cfg_smart     = value[FIELD_W-1:0];
            REG_DAY_ONE:   cfg_day_one   = value[0];
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [INTERVAL_W-1:0] iv, logic [FIELD_W-1:0] st,
                                logic [FIELD_W-1:0] en, logic unb, logic skip,
                                logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] smart,
                                logic day_one);
        write_reg(REG_INTERVAL,  CFG_DATA_W'(iv));
        write_reg(REG_START,     CFG_DATA_W'(st));
        write_reg(REG_END,       CFG_DATA_W'(en));
        write_reg(REG_UNBOUNDED, CFG_DATA_W'(unb));
        write_reg(REG_SKIP,      CFG_DATA_W'(skip));
        write_reg(REG_BASE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_SMART,     CFG_DATA_W'(smart));
        write_reg(REG_DAY_ONE,   CFG_DATA_W'(day_one));
    endtask

    // Draw a schedule setting; extremes of the interval turn up now and then.
    task automatic pick_random_config();
        logic [INTERVAL_W-1:0] iv;
        logic [63:0]           span;
        logic [FIELD_W-1:0]    anchor;
        int                    pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            iv = $urandom_range(1, 200);
        else if (pick < 16)
            iv = $urandom_range(1, 100000);
        else if (pick < 18)
            iv = $urandom;
        else
            iv = (pick == 18) ? {INTERVAL_W{1'b1}} : INTERVAL_W'(1);
        if (iv == '0)
            iv = INTERVAL_W'(1);
        span   = {32'd0, iv};
        anchor = ($urandom_range(0, 3) == 0) ? rand_time()
                                             : FIELD_W'($urandom_range(0, 1000000));
        apply_config(iv,
                     anchor + FIELD_W'(jitter(3 * span)),
                     anchor + FIELD_W'(jitter(40 * span)),
                     1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     MODE_W'($urandom_range(0, 2)),
                     anchor + FIELD_W'(jitter(3 * span)),
                     $urandom_range(0, 3) == 0);
        sched_anchor = anchor;
        sched_clock  = anchor - FIELD_W'(jitter(3 * span));
    endtask

    // Mostly well-formed runs (calculate, finish, set finish with time moving
    // forward), with about one draw in five giving a noise event instead.
    task automatic run_schedule_burst(int count);
        logic [63:0]        iv;
        logic [FIELD_W-1:0] t;
        logic [FIELD_W-1:0] noise_now;
        int                 sent;
        iv   = period();
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                noise_now = $urandom_range(0, 1) ? rand_time()
                                                 : sched_anchor + FIELD_W'(jitter(50 * iv));
                send_event(FUNC_W'($urandom_range(0, 2)), noise_now, rand_time());
                sent++;
            end else begin
                send_event(FUNC_CALC, sched_clock, rand_time());
                sent++;
                if ($urandom_range(0, 1)) begin
                    t = sched_clock + FIELD_W'(jitter(2 * iv));
                    send_event(FUNC_FINISH, t, rand_time());
                    sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    t = sched_clock + FIELD_W'(jitter(2 * iv));
                    send_event(FUNC_SET, t + FIELD_W'(jitter(iv + 1)), t);
                    sent++;
                end
                sched_clock = sched_clock + FIELD_W'(jitter(3 * iv));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Defaults after reset, a bounded end, and reschedule before any calculate.
    task automatic test_reset_state();
        write_reg(REG_END, CFG_DATA_W'(1000));
        write_reg(REG_UNBOUNDED, CFG_DATA_W'(0));
        send_event(FUNC_FINISH, 40'd0, 40'd0);      // not past start: drop
        send_event(FUNC_SET, 40'd10, 40'd20);       // given after now: drop
        send_event(FUNC_SET, 40'd500, 40'd300);     // accepted
        send_event(FUNC_CALC, 40'd0, TIME_MAX);     // now at base
        send_event(FUNC_CALC, 40'd125, 40'd0);      // third tick
        send_event(FUNC_FINISH, 40'd400, 40'd0);
        send_event(FUNC_CALC, 40'd1000, 40'd0);     // missed ticks: catch-up
        wait_results_done();
    endtask

    // Field extremes, wrap-around, zero interval, alias base mode, unknown code.
    task automatic test_extremes();
        apply_config({INTERVAL_W{1'b1}}, 40'd0, TIME_MAX, 1'b0, 1'b0, BASE_START,
                     TIME_MAX, 1'b1);
        send_event(FUNC_CALC, TIME_MAX, TIME_MAX);
        send_event(FUNC_FINISH, TIME_MAX, 40'd0);
        send_event(FUNC_SET, TIME_MAX, TIME_MAX - 40'd1);
        send_event(FUNC_SET, 40'd0, TIME_MAX);
        send_event(FUNC_CALC, 40'd0, 40'd0);
        wait_results_done();

        apply_config('0, 40'd5, 40'd0, 1'b0, 1'b1, BASE_ALIAS, TIME_MAX - 40'd5, 1'b0);
        send_event(FUNC_CALC, TIME_MAX, 40'd0);     // sum wraps to zero
        send_event(FUNC_NONE, rand_time(), rand_time());
        send_event(FUNC_CALC, TIME_MAX - 40'd5, TIME_MAX);
        wait_results_done();

        apply_config(INTERVAL_W'(1), TIME_MAX, TIME_MAX, 1'b1, 1'b0, BASE_LAST,
                     40'd0, 1'b0);
        send_event(FUNC_FINISH, TIME_MAX, 40'd0);
        send_event(FUNC_CALC, 40'd0, 40'd0);
        wait_results_done();
    endtask

    task automatic test_random_schedules(int phases, int per_phase);
        repeat (phases) begin
            pick_random_config();
            run_schedule_burst(per_phase);
            wait_results_done();
        end
    endtask

    // Long receiver hold-off while events keep coming: input must stall.
    task automatic test_output_hold();
        pick_random_config();
        hold_trigger = ~hold_trigger;
        run_schedule_burst(16);
        wait_results_done();
    endtask

    // Sender pauses until every result is back, several times.
    task automatic test_sender_pause();
        pick_random_config();
        repeat (8) begin
            run_schedule_burst(3);
            wait_results_done();
        end
    endtask

    // Stretch with no idling on either side.
    task automatic test_quiet_stretch();
        quiet = 1'b1;
        test_random_schedules(2, 80);
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no event outstanding: next_start %h", o_next_start);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("next_start", want.next_start, o_next_start);
                check_field("next_known", FIELD_W'(want.next_known), FIELD_W'(o_next_known));
                check_field("reschedule", FIELD_W'(want.reschedule), FIELD_W'(o_reschedule));
                check_field("last_finish", want.last_finish, o_last_finish);
                check_field("last_finish_known", FIELD_W'(want.last_finish_known),
                            FIELD_W'(o_last_finish_known));
            end
        end
        // pick up a hold-off request and count it down here
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 6);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles in a row without a transfer on any channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $error("no transfer for %0d cycles, %0d results outstanding",
                       idle_cycles, pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // known values on every input from time zero
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_func         <= FUNC_CALC;
        i_now_time     <= '0;
        i_given_finish <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_INTERVAL;
        i_cfg_data     <= '0;

        // shadow registers and state as after reset
        cfg_interval       = INTERVAL_RESET;
        cfg_start          = '0;
        cfg_end            = '0;
        cfg_unbounded      = 1'b1;
        cfg_skip           = 1'b0;
        cfg_base_mode      = BASE_SMART;
        cfg_smart          = '0;
        cfg_day_one        = 1'b0;
        sched_next         = '0;
        sched_next_known   = 1'b0;
        sched_last_finish  = '0;
        sched_finish_known = 1'b0;
        sched_anchor       = '0;
        sched_clock        = '0;
        quiet              = 1'b0;
        hold_trigger       = 1'b0;
        hold_seen          = 1'b0;
        hold_left          = 0;
        fail_count         = 0;
        results_checked    = 0;
        reg_writes         = 0;
        idle_cycles        = 0;
        event_count        = '{default: 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_random_schedules(12, 70);
        test_output_hold();
        test_quiet_stretch();
        test_sender_pause();
        test_random_schedules(3, 40);
        test_output_hold();

        wait_results_done();
        $display("Covered %0d events (%0d calculate, %0d finish, %0d set, %0d unknown code)",
                 event_count[0] + event_count[1] + event_count[2] + event_count[3],
                 event_count[0], event_count[1], event_count[2], event_count[3]);
        $display("over %0d register writes; %0d results compared, %0d field mismatches",
                 reg_writes, results_checked, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
